// ===== hw/rtl/grid_key_node_lookup_unit_assert.svh =====
`ifndef GRID_KEY_NODE_LOOKUP_UNIT_ASSERT_SVH
`define GRID_KEY_NODE_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define GKN_ASSERT_IMP(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("gkn assertion failed");

// next-cycle implication
`define GKN_ASSERT_NXT(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("gkn assertion failed");

`endif

// ===== hw/rtl/gkn_pkg.sv =====
package gkn_pkg;

  localparam int MAXD      = 4;
  localparam int DATA_W    = 32;
  localparam int RES_W     = 31;
  localparam int ID_W      = 10;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 32;
  localparam int DCNT_W    = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIM,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_RD,
    ST_CMP,
    ST_HIT,
    ST_MISS,
    ST_OUT
  } gkn_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gkn_divider.sv =====
module gkn_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  gkn_pkg::div_req_t req,
  output gkn_pkg::div_rsp_t rsp
);
  import gkn_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic              fit;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r[DATA_W-1:0];

endmodule

// ===== hw/rtl/grid_key_node_lookup_unit.sv =====
// Grid key node lookup: quantizes a four-component Q16.16 state onto a grid
// and finds or creates the matching node entry.
// Channels: in_ (s0..s3), out_ (node id, is_new, table_full, node state),
// cfg_ (write index 0..3 sets res_0..res_3; other indexes are dropped,
// cfg_ready is always high). Write cfg only while the block is idle.
// One word at a time: in_ready is high only when idle. Each dimension with a
// nonzero resolution goes through the shared serial divider (33 quotient
// bits), then multiply and saturate; other dimensions skip all three.
// The key search reads and compares one stored entry at a time (RD, CMP),
// then a HIT or MISS state sets the result.
// The result sits in the output register until out_ready; the block takes
// no new word until the result is taken.
// Reset clears resolutions, the entry count and the sequencer; the node
// memories are not cleared, entries beyond the count are never matched.
module grid_key_node_lookup_unit #(
  parameter int DIMS     = 4,
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gkn_pkg::DATA_W-1:0]   in_s0,
  input  logic signed [gkn_pkg::DATA_W-1:0]   in_s1,
  input  logic signed [gkn_pkg::DATA_W-1:0]   in_s2,
  input  logic signed [gkn_pkg::DATA_W-1:0]   in_s3,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gkn_pkg::ID_W-1:0]            out_node_id,
  output logic                                out_is_new,
  output logic                                out_table_full,
  output logic signed [gkn_pkg::DATA_W-1:0]   out_node_s0,
  output logic signed [gkn_pkg::DATA_W-1:0]   out_node_s1,
  output logic signed [gkn_pkg::DATA_W-1:0]   out_node_s2,
  output logic signed [gkn_pkg::DATA_W-1:0]   out_node_s3,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gkn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gkn_pkg::DATA_W-1:0]          cfg_data
);
  import gkn_pkg::*;
  `include "grid_key_node_lookup_unit_assert.svh"

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VEC_W = MAXD * DATA_W;

  gkn_state_t state_r, state_nxt;

  logic [1:0]              d_r;
  logic [CNT_W-1:0]        e_r;
  logic [CNT_W-1:0]        used_r;
  logic [DATA_W-1:0]       s_r   [MAXD];
  logic [RES_W-1:0]        res_r [MAXD];
  logic [VEC_W-1:0]        key_r;
  logic [VEC_W-1:0]        snap_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [VEC_W-1:0]        key_q;
  logic [VEC_W-1:0]        node_q;
  logic [VEC_W-1:0]        key_mem  [CAPACITY];
  logic [VEC_W-1:0]        node_mem [CAPACITY];
  logic [CNT_W-1:0]        id_r;
  logic                    new_r;
  logic                    full_r;
  logic [VEC_W-1:0]        ostate_r;

  div_req_t          dreq;
  div_rsp_t          drsp;
  logic [DATA_W-1:0] cur_s;
  logic [RES_W-1:0]  cur_res;
  logic              dim_on;
  logic              neg;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] qkey;
  logic              last_d;
  logic              accept;

  assign accept  = in_valid && in_ready;
  assign cur_s   = s_r[d_r];
  assign cur_res = res_r[d_r];
  assign dim_on  = 32'(d_r) < DIMS;
  assign last_d  = d_r == 2'(MAXD - 1);
  assign neg     = cur_s[DATA_W-1];
  assign mag     = neg ? DATA_W'(-cur_s) : cur_s;

  always_comb begin
    if (!neg) begin
      qkey = drsp.quo[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : drsp.quo;
    end else begin
      qkey = DATA_W'(-drsp.quo);
    end
  end

  assign dreq.start = (state_r == ST_DIM) && dim_on && (cur_res != '0);
  assign dreq.num   = {mag, 1'b0} + NUM_W'(cur_res);
  assign dreq.den   = {cur_res, 1'b0};

  gkn_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_DIM;
      ST_DIM: begin
        if (dreq.start) state_nxt = ST_DIV;
        else if (last_d) state_nxt = ST_RD;
      end
      ST_DIV:  if (drsp.done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = last_d ? ST_RD : ST_DIM;
      ST_RD:   state_nxt = (e_r >= used_r) ? ST_MISS : ST_CMP;
      ST_CMP:  state_nxt = (key_q == key_r) ? ST_HIT : ST_RD;
      ST_HIT:  state_nxt = ST_OUT;
      ST_MISS: state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < MAXD; i++) res_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(MAXD)) begin
        res_r[cfg_index[1:0]] <= cfg_data[RES_W-1:0];
      end
      if (state_r == ST_MISS && used_r < CNT_W'(CAPACITY)) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          s_r[0] <= in_s0;
          s_r[1] <= in_s1;
          s_r[2] <= in_s2;
          s_r[3] <= in_s3;
          key_r  <= '0;
          snap_r <= '0;
          d_r    <= '0;
          e_r    <= '0;
        end
      end
      ST_DIM: begin
        if (!dreq.start) begin
          if (dim_on) snap_r[d_r*DATA_W +: DATA_W] <= cur_s;
          d_r <= d_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (drsp.done) key_r[d_r*DATA_W +: DATA_W] <= qkey;
      end
      ST_MUL: begin
        prod_r <= $signed(key_r[d_r*DATA_W +: DATA_W]) * $signed({1'b0, cur_res});
      end
      ST_SAT: begin
        if (prod_r[2*DATA_W-1:DATA_W-1] == '0 || prod_r[2*DATA_W-1:DATA_W-1] == '1) begin
          snap_r[d_r*DATA_W +: DATA_W] <= prod_r[DATA_W-1:0];
        end else begin
          snap_r[d_r*DATA_W +: DATA_W] <=
            prod_r[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        d_r <= d_r + 1'b1;
      end
      ST_RD: begin
        key_q <= key_mem[e_r[AW-1:0]];
      end
      ST_CMP: begin
        node_q <= node_mem[e_r[AW-1:0]];
        if (key_q != key_r) e_r <= e_r + 1'b1;
      end
      ST_HIT: begin
        id_r     <= e_r;
        new_r    <= 1'b0;
        full_r   <= 1'b0;
        ostate_r <= node_q;
      end
      ST_MISS: begin
        if (used_r < CNT_W'(CAPACITY)) begin
          key_mem[used_r[AW-1:0]]  <= key_r;
          node_mem[used_r[AW-1:0]] <= snap_r;
          id_r     <= used_r;
          new_r    <= 1'b1;
          full_r   <= 1'b0;
          ostate_r <= snap_r;
        end else begin
          id_r     <= '0;
          new_r    <= 1'b0;
          full_r   <= 1'b1;
          ostate_r <= '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready       = state_r == ST_IDLE;
  assign out_valid      = state_r == ST_OUT;
  assign cfg_ready      = 1'b1;
  assign out_node_id    = ID_W'(id_r);
  assign out_is_new     = new_r;
  assign out_table_full = full_r;
  assign out_node_s0    = ostate_r[0*DATA_W +: DATA_W];
  assign out_node_s1    = ostate_r[1*DATA_W +: DATA_W];
  assign out_node_s2    = ostate_r[2*DATA_W +: DATA_W];
  assign out_node_s3    = ostate_r[3*DATA_W +: DATA_W];

  `GKN_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  `GKN_ASSERT_IMP(a_full_clean, clk, rst_n, out_valid && out_table_full,
                  !out_is_new && out_node_id == '0)
  `GKN_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= CNT_W'(CAPACITY))
  `GKN_ASSERT_NXT(a_busy_after, clk, rst_n, accept, !in_ready)

endmodule
